// ===== hdl/snappy_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the snappy block decompressor
// no dependencies

package snappy_pkg;

  localparam int unsigned WindowBytes = 65536;
  localparam int unsigned WinAw = $clog2(WindowBytes);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_HDR   = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_BAD_OFF   = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_MISMATCH  = 3'd6
  } status_e;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_TAG    = 3'd1;
  localparam logic [2:0] PH_EXTRA  = 3'd2;
  localparam logic [2:0] PH_LIT    = 3'd3;
  localparam logic [2:0] PH_DRAIN  = 3'd4;
  localparam logic [2:0] PH_COPY   = 3'd5;

  localparam logic [5:0] LitLenTagMin = 6'd60;
  localparam logic [2:0] CopyLenMask  = 3'h7;
  localparam logic [2:0] CopyMinLen   = 3'd4;
  localparam logic [2:0] Copy4Extra   = 3'd4;
  localparam logic [6:0] CopyMaxRun   = 7'd64;

  typedef struct packed {
    logic       we;
    logic [WinAw-1:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [WinAw-1:0] raddr;
  } hist_req_t;

endpackage

// ===== hdl/snappy_block_decompressor.sv =====
`timescale 1ns / 1ps
// snappy raw block decompressor top level
// depends on snappy_pkg and snappy_hist_ram
//
// input channel: one compressed byte per transfer with last_in_i marking the
// end of a stream. output channel: one result per transfer with a byte flag,
// a stream end flag, a status and a flag on the last result of an input byte.
// header, tag and extra bytes give at most a status result. literal data
// bytes pass through at one per cycle while the receiver does not stall.
// a copy tag replays its bytes one per cycle, while the receiver does not
// stall, from the history memory, whose registered read precedes the first
// byte; the input is held off until the copy's last byte has been produced.
// results come from a single output register; input is taken only when that
// register is empty or being drained in the same cycle, so a stalled receiver
// holds the block with no loss.
// reset clears the parse state and sets the capacity register to all ones;
// the history memory needs no clearing as a copy only reads bytes already
// written in the same stream.
// the user must write the capacity register (out_capacity_we_i) only while the block is idle; not enforced

module snappy_block_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_capacity_we_i,
  input  logic [31:0] out_capacity_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        has_byte_o,
  output logic        stream_end_o,
  output logic [2:0]  status_o,
  output logic        last_of_run_o
);
  import snappy_pkg::*;

  logic [31:0] cap_q;
  logic [2:0]  phase_q, phase_d;
  logic [31:0] total_q, total_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [1:0]  kind_q, kind_d;
  logic [2:0]  pend_q, pend_d;
  logic [32:0] run_q, run_d;
  logic [31:0] off_q, off_d;
  logic [31:0] prod_q, prod_d;
  logic        clast_q, clast_d;
  logic        rdv_q, rdv_d;
  logic [6:0]  crem_q, crem_d;
  logic        fwd_q, fwd_d;
  logic [7:0]  fwd_b_q, fwd_b_d;

  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        oh_q, oh_d, oe_q, oe_d, ol_q, ol_d;
  logic [2:0]  os_q, os_d;

  hist_req_t   req;
  logic [7:0]  rdata;

  snappy_hist_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  logic        oslot;
  logic        take;
  logic [7:0]  b;
  logic [32:0] room;
  logic [5:0]  f;
  logic [4:0]  sh;
  logic [2:0]  err;
  logic        emit;
  logic [32:0] run_n;
  logic [31:0] off_n;
  logic [7:0]  cdat;

  assign oslot      = !ov_q || !out_stall_i;
  assign in_stall_o = !(oslot && phase_q != PH_COPY);
  assign take       = in_valid_i && !in_stall_o;
  assign b          = in_byte_i;
  assign f          = b[7:2];
  assign room       = {1'b0, total_q - prod_q};
  assign sh         = {hcnt_q[1:0], 3'b000};
  // offset of one reads the byte written in the same cycle
  assign cdat       = fwd_q ? fwd_b_q : rdata;

  always_comb begin
    phase_d = phase_q; total_d = total_q; hcnt_d = hcnt_q; kind_d = kind_q;
    pend_d = pend_q; run_d = run_q; off_d = off_q; prod_d = prod_q;
    clast_d = clast_q; rdv_d = 1'b0; crem_d = crem_q;
    fwd_d = fwd_q; fwd_b_d = fwd_b_q;
    ov_d = ov_q && out_stall_i; ob_d = ob_q; oh_d = oh_q; oe_d = oe_q;
    os_d = os_q; ol_d = ol_q;
    req = '0;
    err = ST_OK;
    emit = 1'b0;
    run_n = run_q;
    off_n = off_q;

    if (phase_q == PH_COPY) begin
      req.raddr = WinAw'(prod_q - off_q);
      if (oslot) begin
        if (rdv_q) begin
          req.we = 1'b1;
          req.waddr = WinAw'(prod_q);
          req.wdata = cdat;
          prod_d = prod_q + 32'd1;
          req.raddr = WinAw'(prod_q + 32'd1 - off_q);
          ov_d = 1'b1; ob_d = cdat; oh_d = 1'b1;
          os_d = ST_OK; oe_d = 1'b0; ol_d = 1'b0;
          crem_d = crem_q - 7'd1;
          if (crem_q == 7'd1) begin
            ol_d = 1'b1;
            phase_d = PH_TAG;
            if (clast_q) begin
              oe_d = 1'b1;
              os_d = (prod_q + 32'd1 == total_q) ? ST_OK : ST_MISMATCH;
              phase_d = PH_HEADER; total_d = '0; hcnt_d = '0; kind_d = '0;
              pend_d = '0; run_d = '0; off_d = '0; prod_d = '0;
            end
          end else begin
            req.re = 1'b1; rdv_d = 1'b1;
            fwd_d = (off_q == 32'd1);
            fwd_b_d = cdat;
          end
        end else begin
          req.re = 1'b1; rdv_d = 1'b1;
          fwd_d = 1'b0;
        end
      end else begin
        rdv_d = rdv_q;
      end
    end else if (take) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (hcnt_q < 3'd4) begin
            total_d = total_q | ({25'd0, b[6:0]} << (5'd7 * {2'b00, hcnt_q}));
            if (b[7]) hcnt_d = hcnt_q + 3'd1;
          end else if (b >= 8'd16) begin
            err = ST_BAD_HDR;
          end else begin
            total_d = total_q | {b[3:0], 28'd0};
          end
          if (err == ST_OK && !(hcnt_q < 3'd4 && b[7])) begin
            hcnt_d = '0;
            if (total_d > cap_q) err = ST_TOO_LONG;
            else phase_d = PH_TAG;
          end
        end
        PH_TAG: begin
          kind_d = b[1:0];
          hcnt_d = '0;
          off_d = '0;
          if (b[1:0] == 2'd0) begin
            if (f < LitLenTagMin) begin
              run_d = {27'd0, f} + 33'd1;
              if (room < run_d) err = ST_OVERFLOW;
              else phase_d = PH_LIT;
            end else begin
              run_d = '0;
              pend_d = 3'(f - 6'd59);
              phase_d = PH_EXTRA;
            end
          end else if (b[1:0] == 2'd1) begin
            run_d = {30'd0, CopyMinLen} + {30'd0, b[4:2] & CopyLenMask};
            off_d = {21'd0, b[7:5], 8'd0};
            pend_d = 3'd1;
            phase_d = PH_EXTRA;
          end else begin
            run_d = {27'd0, f} + 33'd1;
            pend_d = (b[1:0] == 2'd2) ? 3'd2 : Copy4Extra;
            phase_d = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          if (kind_q == 2'd0) run_n = run_q | ({25'd0, b} << sh);
          else off_n = off_q | ({24'd0, b} << sh);
          run_d = run_n;
          off_d = off_n;
          hcnt_d = hcnt_q + 3'd1;
          pend_d = pend_q - 3'd1;
          if (pend_q == 3'd1) begin
            hcnt_d = '0;
            if (kind_q == 2'd0) begin
              run_d = run_n + 33'd1;
              if (room < run_d) err = ST_OVERFLOW;
              else phase_d = PH_LIT;
            end else if (off_n == 32'd0 || off_n > prod_q ||
                         {1'b0, off_n} > 33'(WindowBytes)) begin
              err = ST_BAD_OFF;
            end else if (room < run_n) begin
              err = ST_OVERFLOW;
            end else begin
              phase_d = PH_COPY;
              clast_d = last_in_i;
              crem_d = CopyMaxRun;
              if (run_n < 33'(CopyMaxRun)) crem_d = run_n[6:0];
            end
          end
        end
        PH_LIT: begin
          emit = 1'b1;
          req.we = 1'b1;
          req.waddr = WinAw'(prod_q);
          req.wdata = b;
          prod_d = prod_q + 32'd1;
          run_d = run_q - 33'd1;
          if (run_q == 33'd1) phase_d = PH_TAG;
        end
        default: begin
        end
      endcase

      if (phase_q == PH_DRAIN) begin
        if (last_in_i) begin
          phase_d = PH_HEADER; total_d = '0; hcnt_d = '0; kind_d = '0;
          pend_d = '0; run_d = '0; off_d = '0; prod_d = '0;
        end
      end else if (phase_d != PH_COPY) begin
        if (err == ST_OK && last_in_i) begin
          if (phase_d == PH_TAG)
            err = (prod_d == total_d) ? ST_OK : ST_MISMATCH;
          else if (phase_d == PH_HEADER) err = ST_BAD_HDR;
          else err = ST_TRUNC;
        end
        if (emit || err != ST_OK || last_in_i) begin
          ov_d = 1'b1;
          ob_d = emit ? b : 8'd0;
          oh_d = emit;
          oe_d = (err != ST_OK) || last_in_i;
          os_d = err;
          ol_d = 1'b1;
        end
        if (err != ST_OK || last_in_i) begin
          if (last_in_i) begin
            phase_d = PH_HEADER; total_d = '0; hcnt_d = '0; kind_d = '0;
            pend_d = '0; run_d = '0; off_d = '0; prod_d = '0;
          end else begin
            phase_d = PH_DRAIN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '1;
      phase_q <= PH_HEADER; total_q <= '0; hcnt_q <= '0; kind_q <= '0;
      pend_q <= '0; run_q <= '0; off_q <= '0; prod_q <= '0;
      clast_q <= 1'b0; rdv_q <= 1'b0; crem_q <= '0; ov_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      if (out_capacity_we_i) cap_q <= out_capacity_i;
      phase_q <= phase_d; total_q <= total_d; hcnt_q <= hcnt_d;
      kind_q <= kind_d; pend_q <= pend_d; run_q <= run_d; off_q <= off_d;
      prod_q <= prod_d; clast_q <= clast_d; rdv_q <= rdv_d;
      crem_q <= crem_d; ov_q <= ov_d; fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d; oh_q <= oh_d; oe_q <= oe_d; os_q <= os_d; ol_q <= ol_d;
    fwd_b_q <= fwd_b_d;
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = ob_q;
  assign has_byte_o    = oh_q;
  assign stream_end_o  = oe_q;
  assign status_o      = os_q;
  assign last_of_run_o = ol_q;

endmodule

// ===== hdl/snappy_hist_ram.sv =====
`timescale 1ns / 1ps
// history window memory: one write and one registered read port
// depends on snappy_pkg

module snappy_hist_ram (
  input  logic                  clk_i,
  input  snappy_pkg::hist_req_t req_i,
  output logic [7:0]            rdata_o
);
  import snappy_pkg::*;

  logic [7:0] mem_q [WindowBytes];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

// ===== hdl/snappy_checker.sv =====
`timescale 1ns / 1ps
// port level checks for the snappy block decompressor
// bound to snappy_block_decompressor

module snappy_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       has_byte_o,
  input logic       stream_end_o,
  input logic [2:0] status_o,
  input logic       last_of_run_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(status_o))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stream_end_o |-> status_o == 3'd0)
    else $error("status without stream end");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> last_of_run_o)
    else $error("stream end not last of run");

  a_nobyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> stream_end_o)
    else $error("empty result without stream end");

endmodule

bind snappy_block_decompressor snappy_checker u_checker (.*);
